>>> hw/rtl/spimrb_pkg.sv
// Package for the SPI master register block: register offsets, bit positions,
// bus access codes and the request/result structures.
// No dependencies; used by spimrb_core and spi_master_register_block.
package spimrb_pkg;

    // Bus access kind
    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    // Register byte offsets
    localparam logic [11:0] OFS_CTRL1  = 12'd0;
    localparam logic [11:0] OFS_CTRL2  = 12'd4;
    localparam logic [11:0] OFS_STATUS = 12'd8;
    localparam logic [11:0] OFS_DATA   = 12'd12;
    localparam logic [11:0] OFS_CSCTRL = 12'd16;

    // Control 1 bits
    localparam int C1_SPE  = 6;
    localparam int C1_MSTR = 2;

    // Control 2 bits
    localparam int C2_TXEIE  = 7;
    localparam int C2_RXNEIE = 6;
    localparam int C2_ERRIE  = 5;

    // Status bits
    localparam int ST_RXNE = 0;
    localparam int ST_TXE  = 1;
    localparam int ST_UDR  = 3;
    localparam int ST_OVR  = 6;
    localparam int ST_BSY  = 7;

    localparam logic [7:0] STATUS_RESET = 8'h02;

    // Chip-select control bits
    localparam int CS0_EN  = 0;
    localparam int CS1_EN  = 1;
    localparam int CS0_ACT = 4;
    localparam int CS1_ACT = 5;

    // One bus access request
    typedef struct packed {
        logic        action;
        logic [11:0] address;
        logic [31:0] write_data;
        logic [7:0]  slave_byte;
    } req_t;

    // One access result
    typedef struct packed {
        logic [31:0] read_data;
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        select0_n;
        logic        select1_n;
        logic        interrupt;
    } result_t;

endpackage

>>> hw/rtl/spimrb_core.sv
// Register file and access logic of the SPI master register block.
// Holds the programmer-visible state and works out one result per request.
// Depends on spimrb_pkg.
module spimrb_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  spimrb_pkg::req_t   req,
    output spimrb_pkg::result_t res
);

    logic [31:0] ctrl1_reg, ctrl1_next;
    logic [31:0] ctrl2_reg, ctrl2_next;
    logic [7:0]  status_reg, status_next;
    logic [7:0]  txbyte_reg, txbyte_next;
    logic [31:0] csctrl_reg, csctrl_next;
    logic [7:0]  rxbyte_reg, rxbyte_next;

    logic [31:0] rdata;
    logic        txv;
    logic [7:0]  txb;
    logic        cs0_pre, cs1_pre;
    logic        cs0_post, cs1_post;

    // Chip selects as seen before the access
    assign cs0_pre = csctrl_reg[spimrb_pkg::CS0_EN] & csctrl_reg[spimrb_pkg::CS0_ACT];
    assign cs1_pre = csctrl_reg[spimrb_pkg::CS1_EN] & csctrl_reg[spimrb_pkg::CS1_ACT];

    // Access decode and next state
    always_comb begin
        ctrl1_next  = ctrl1_reg;
        ctrl2_next  = ctrl2_reg;
        status_next = status_reg;
        txbyte_next = txbyte_reg;
        csctrl_next = csctrl_reg;
        rxbyte_next = rxbyte_reg;
        rdata       = '0;
        txv         = 1'b0;
        txb         = '0;
        if (accept) begin
            if (req.action == spimrb_pkg::ACT_WRITE) begin
                case (req.address)
                    spimrb_pkg::OFS_CTRL1: begin
                        ctrl1_next = req.write_data;
                    end
                    spimrb_pkg::OFS_CTRL2: begin
                        ctrl2_next = req.write_data;
                    end
                    spimrb_pkg::OFS_STATUS: begin
                        // write-one-to-clear on OVR and UDR only
                        status_next[spimrb_pkg::ST_OVR] = status_reg[spimrb_pkg::ST_OVR]
                            & ~req.write_data[spimrb_pkg::ST_OVR];
                        status_next[spimrb_pkg::ST_UDR] = status_reg[spimrb_pkg::ST_UDR]
                            & ~req.write_data[spimrb_pkg::ST_UDR];
                    end
                    spimrb_pkg::OFS_DATA: begin
                        txbyte_next = req.write_data[7:0];
                        if (ctrl1_reg[spimrb_pkg::C1_SPE] && ctrl1_reg[spimrb_pkg::C1_MSTR]
                                && (cs0_pre != cs1_pre)) begin
                            // one-byte exchange; overrun if the last byte was not read
                            if (status_reg[spimrb_pkg::ST_RXNE]) begin
                                status_next[spimrb_pkg::ST_OVR] = 1'b1;
                            end
                            rxbyte_next                      = req.slave_byte;
                            status_next[spimrb_pkg::ST_RXNE] = 1'b1;
                            status_next[spimrb_pkg::ST_TXE]  = 1'b1;
                            status_next[spimrb_pkg::ST_BSY]  = 1'b0;
                            txv                              = 1'b1;
                            txb                              = req.write_data[7:0];
                        end
                    end
                    spimrb_pkg::OFS_CSCTRL: begin
                        csctrl_next = req.write_data;
                    end
                    default: begin
                    end
                endcase
            end else begin
                case (req.address)
                    spimrb_pkg::OFS_CTRL1:  rdata = ctrl1_reg;
                    spimrb_pkg::OFS_CTRL2:  rdata = ctrl2_reg;
                    spimrb_pkg::OFS_STATUS: rdata = {24'd0, status_reg};
                    spimrb_pkg::OFS_DATA: begin
                        rdata                            = {24'd0, rxbyte_reg};
                        status_next[spimrb_pkg::ST_RXNE] = 1'b0;
                        status_next[spimrb_pkg::ST_OVR]  = 1'b0;
                    end
                    spimrb_pkg::OFS_CSCTRL: rdata = csctrl_reg;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Selects and interrupt follow the state after the access
    assign cs0_post = csctrl_next[spimrb_pkg::CS0_EN] & csctrl_next[spimrb_pkg::CS0_ACT];
    assign cs1_post = csctrl_next[spimrb_pkg::CS1_EN] & csctrl_next[spimrb_pkg::CS1_ACT];

    always_comb begin
        res.read_data = rdata;
        res.tx_valid  = txv;
        res.tx_byte   = txb;
        res.select0_n = ~cs0_post;
        res.select1_n = ~cs1_post;
        res.interrupt =
            (ctrl2_next[spimrb_pkg::C2_TXEIE] & status_next[spimrb_pkg::ST_TXE])
          | (ctrl2_next[spimrb_pkg::C2_RXNEIE] & status_next[spimrb_pkg::ST_RXNE])
          | (ctrl2_next[spimrb_pkg::C2_ERRIE]
             & (status_next[spimrb_pkg::ST_UDR] | status_next[spimrb_pkg::ST_OVR]));
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl1_reg  <= '0;
            ctrl2_reg  <= '0;
            status_reg <= spimrb_pkg::STATUS_RESET;
            txbyte_reg <= '0;
            csctrl_reg <= '0;
            rxbyte_reg <= '0;
        end else begin
            ctrl1_reg  <= ctrl1_next;
            ctrl2_reg  <= ctrl2_next;
            status_reg <= status_next;
            txbyte_reg <= txbyte_next;
            csctrl_reg <= csctrl_next;
            rxbyte_reg <= rxbyte_next;
        end
    end

    // An exchange needs exactly one chip select driven low
    assert property (@(posedge aclk) disable iff (!aresetn)
        txv |-> (cs0_post != cs1_post))
        else $error("exchange without a single active chip select");

    // An exchange leaves the received byte flagged
    assert property (@(posedge aclk) disable iff (!aresetn)
        txv |=> status_reg[spimrb_pkg::ST_RXNE])
        else $error("RXNE not set after exchange");

    // The busy flag never reads as set
    assert property (@(posedge aclk) disable iff (!aresetn)
        !status_reg[spimrb_pkg::ST_BSY])
        else $error("BSY flag set");

endmodule

>>> hw/rtl/spi_master_register_block.sv
// SPI master register block, top level: stream handshake, result register
// and skid stage around spimrb_core. Depends on spimrb_pkg and spimrb_core.
// A request's result is registered in the output register, or in the skid while the output stalls.
// Throughput: one request per cycle while the skid is empty; a one-entry skid keeps
// s_tready high for one more request while a result waits on m_tready.
// Reset: synchronous, active low; core registers and valid flags reset, payload registers do not.
module spi_master_register_block (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // address[11:0], write_data[43:12], slave_byte[51:44], zeros
    input  logic        s_tuser,   // action (0 read, 1 write)
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // read_data[31:0], tx_byte[39:32], select0_n[40],
                                   // select1_n[41], interrupt[42], zeros
    output logic        m_tuser    // tx_valid
);

    spimrb_pkg::req_t    req;
    spimrb_pkg::result_t res;
    spimrb_pkg::result_t out_reg;
    spimrb_pkg::result_t skid_reg;
    logic                out_valid_reg;
    logic                skid_valid_reg;
    logic                accept;

    assign s_tready = ~skid_valid_reg;
    assign accept   = s_tvalid & s_tready;

    // Unpack the request
    assign req.action     = s_tuser;
    assign req.address    = s_tdata[11:0];
    assign req.write_data = s_tdata[43:12];
    assign req.slave_byte = s_tdata[51:44];

    spimrb_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .req     (req),
        .res     (res)
    );

    // Output and skid valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_tready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= accept;
            end
        end else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (m_tready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (accept) begin
                out_reg <= res;
            end
        end else if (accept) begin
            skid_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.tx_valid;
    assign m_tdata  = {5'd0, out_reg.interrupt, out_reg.select1_n, out_reg.select0_n,
                       out_reg.tx_byte, out_reg.read_data};

    // The skid only fills behind a full output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result while output is empty");

    // A request taken during a stall lands in the skid
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && out_valid_reg && !m_tready) |=> skid_valid_reg)
        else $error("request lost during output stall");

    // A waiting skid drains as soon as the output is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && m_tready) |=> (!skid_valid_reg && out_valid_reg))
        else $error("skid did not drain");

endmodule
